@@ sv/ra_pkg.sv @@
// Shared widths, defaults and interface structs for the rational approximation block.
`default_nettype none
package ra_pkg;

    localparam int DATA_W        = 64;
    localparam int CNT_W         = $clog2(DATA_W);
    localparam int FRAC_BITS_DEF = 32;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quo;
        t_word rem;
    } t_div_res;

    typedef struct packed {
        logic  start;
        t_word term;
        t_word top1;
        t_word top2;
        t_word bot1;
        t_word bot2;
    } t_mac_req;

    typedef struct packed {
        logic  done;
        logic  ovf_top;
        logic  ovf_bot;
        t_word top;
        t_word bot;
    } t_mac_res;

endpackage
`default_nettype wire

@@ sv/ra_div.sv @@
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none
module ra_div
    import ra_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_res      o_res
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_quo;
    t_word            r_rem;
    t_word            r_dsr;

    logic [DATA_W:0]  n_shift;
    logic [DATA_W:0]  n_diff;
    logic             n_bit;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        n_shift = {r_rem, r_quo[DATA_W-1]};
        n_diff  = n_shift - {1'b0, r_dsr};
        n_bit   = !n_diff[DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_dsr <= i_req.divisor;
            end else if (r_run) begin
                r_quo <= {r_quo[DATA_W-2:0], n_bit};
                r_rem <= n_bit ? n_diff[DATA_W-1:0] : n_shift[DATA_W-1:0];
                if (r_cnt == CNT_LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule
`default_nettype wire

@@ sv/ra_mac.sv @@
// Bit-serial multiply-add with overflow detection for both convergent lanes.
`default_nettype none
module ra_mac
    import ra_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_req i_req,
    output t_mac_res      o_res
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    typedef struct packed {
        logic  ovf;
        t_word acc;
    } t_lane;

    // One Horner step: acc = 2*acc + (bit ? prev : 0). The accumulator never
    // shrinks, so any intermediate overflow means the product overflows.
    function automatic t_lane lane_step(t_lane l, logic b, t_word prev);
        t_lane           r;
        logic [DATA_W:0] sum;
        r.ovf = l.ovf | l.acc[DATA_W-1];
        r.acc = {l.acc[DATA_W-2:0], 1'b0};
        sum   = {1'b0, r.acc} + {1'b0, prev};
        if (b) begin
            r.ovf = r.ovf | sum[DATA_W];
            r.acc = sum[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic t_lane lane_add(t_lane l, t_word pp);
        t_lane           r;
        logic [DATA_W:0] sum;
        sum   = {1'b0, l.acc} + {1'b0, pp};
        r.ovf = l.ovf | sum[DATA_W];
        r.acc = sum[DATA_W-1:0];
        return r;
    endfunction

    logic             r_run;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_term;
    t_lane            r_top;
    t_lane            r_bot;

    t_lane            n_top;
    t_lane            n_bot;

    // The previous convergents on the request hold steady while a product runs.
    always_comb begin
        if (r_fin) begin
            n_top = lane_add(r_top, i_req.top2);
            n_bot = lane_add(r_bot, i_req.bot2);
        end else begin
            n_top = lane_step(r_top, r_term[DATA_W-1], i_req.top1);
            n_bot = lane_step(r_bot, r_term[DATA_W-1], i_req.bot1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_fin  <= 1'b0;
                r_cnt  <= '0;
                r_term <= i_req.term;
                r_top  <= '0;
                r_bot  <= '0;
            end else if (r_run) begin
                r_top <= n_top;
                r_bot <= n_bot;
                if (r_fin) begin
                    r_run  <= 1'b0;
                    r_fin  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_term <= {r_term[DATA_W-2:0], 1'b0};
                    if (r_cnt == CNT_LAST) begin
                        r_fin <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
        end
    end

    assign o_res.done    = r_done;
    assign o_res.ovf_top = r_top.ovf;
    assign o_res.ovf_bot = r_bot.ovf;
    assign o_res.top     = r_top.acc;
    assign o_res.bot     = r_bot.acc;

endmodule
`default_nettype wire

@@ sv/rational_approximation.sv @@
// Top level: continued-fraction best rational approximation sequencer.
//
// Usage: drive i_value_fixed, i_max_num and i_max_den and raise start while
// busy is low; the operands are transferred at that clock edge and busy rises.
// The block expands 2^FRAC_BITS / value with integer Euclid steps. Each step
// is a test state, a restoring division of 64 quotient bits and a bit-serial
// multiply-add that forms both new convergents at once. A zero value ends the
// expansion in the test state, with no division.
// When the expansion stops, o_valid is high for exactly one cycle with
// o_numerator and o_denominator, and busy drops in that same cycle, so the
// next start may be given right away. The receiver cannot stall the result
// and must take it in that cycle. Results come in the order of the starts.
// If even the first convergent does not fit, the result is 1/0 for a value above
// one with a numerator limit of at least one, and 0/1 otherwise. Reset clears the
// sequencer and the strobe; any item in progress is dropped.
`default_nettype none
module rational_approximation
    import ra_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [DATA_W-1:0] i_value_fixed,
    input  wire logic [DATA_W-1:0] i_max_num,
    input  wire logic [DATA_W-1:0] i_max_den,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_numerator,
    output logic [DATA_W-1:0]      o_denominator
);

    localparam t_word DIVIDEND_INIT = t_word'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_MAC
    } t_state;

    t_state   r_state;
    logic     r_valid;
    t_word    r_num_out;
    t_word    r_den_out;
    t_word    r_lim_num;
    t_word    r_lim_den;
    t_word    r_dividend;
    t_word    r_divisor;
    t_word    r_rem;
    t_word    r_term;
    t_word    r_top1;
    t_word    r_top2;
    t_word    r_bot1;
    t_word    r_bot2;
    logic     r_div_go;
    logic     r_mac_go;

    t_div_req div_req;
    t_div_res div_res;
    t_mac_req mac_req;
    t_mac_res mac_res;
    logic     mac_stop;

    assign div_req.start    = r_div_go;
    assign div_req.dividend = r_dividend;
    assign div_req.divisor  = r_divisor;

    assign mac_req.start = r_mac_go;
    assign mac_req.term  = r_term;
    assign mac_req.top1  = r_top1;
    assign mac_req.top2  = r_top2;
    assign mac_req.bot1  = r_bot1;
    assign mac_req.bot2  = r_bot2;

    ra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    ra_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_res   (mac_res)
    );

    // The expansion ends on overflow or when the new convergent passes a limit.
    assign mac_stop = mac_res.ovf_top || mac_res.ovf_bot ||
                      (mac_res.bot > r_lim_num) || (mac_res.top > r_lim_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_div_go <= 1'b0;
            r_mac_go <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_div_go <= 1'b0;
            r_mac_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_lim_num  <= i_max_num;
                        r_lim_den  <= i_max_den;
                        r_dividend <= DIVIDEND_INIT;
                        r_divisor  <= i_value_fixed;
                        r_top2     <= '0;
                        r_top1     <= t_word'(1);
                        r_bot2     <= t_word'(1);
                        r_bot1     <= '0;
                        r_state    <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_divisor == '0) begin
                        r_valid   <= 1'b1;
                        r_num_out <= r_bot1;
                        r_den_out <= r_top1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_term   <= div_res.quo;
                        r_rem    <= div_res.rem;
                        r_mac_go <= 1'b1;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_res.done) begin
                        if (mac_stop) begin
                            r_valid   <= 1'b1;
                            r_num_out <= r_bot1;
                            r_den_out <= r_top1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_top2     <= r_top1;
                            r_top1     <= mac_res.top;
                            r_bot2     <= r_bot1;
                            r_bot1     <= mac_res.bot;
                            r_dividend <= r_divisor;
                            r_divisor  <= r_rem;
                            r_state    <= S_TEST;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_numerator   = r_num_out;
    assign o_denominator = r_den_out;

`ifndef SYNTHESIS
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while the sequencer is still running");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start did not raise busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> (r_divisor != '0))
        else $error("division launched with a zero divisor");

    a_mac_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mac_go |-> $past(div_res.done))
        else $error("multiply-add launched without a finished division");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for the rational approximation block: directed and random checked transfers.
module tb_top;
    import ra_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam t_word ONE = t_word'(1) << FRAC_BITS;
    localparam t_word ALL_ONES = '1;

    typedef struct {
        t_word num;
        t_word den;
    } t_ratio;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_word i_value_fixed = '0;
    t_word i_max_num = '0;
    t_word i_max_den = '0;
    logic o_valid;
    t_word o_numerator;
    t_word o_denominator;

    t_ratio pending_ratios[$];
    int n_transfers = 0;
    int n_checked = 0;
    int n_no_fit = 0;
    int n_errors = 0;

    rational_approximation #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_value_fixed(i_value_fixed),
        .i_max_num(i_max_num),
        .i_max_den(i_max_den),
        .o_valid(o_valid),
        .o_numerator(o_numerator),
        .o_denominator(o_denominator)
    );

    always #2 i_clk = ~i_clk;

    // Forms term*prev + prev2 and tells whether it still fits in one word.
    function automatic bit conv_extend(input t_word term, input t_word prev,
                                       input t_word prev2, output t_word ext_val);
        logic [127:0] acc;
        acc = 128'(term) * 128'(prev) + 128'(prev2);
        ext_val = acc[63:0];
        return acc[127:64] == '0;
    endfunction

    // Last continued-fraction convergent of value/2^FRAC_BITS within both limits.
    // The Euclid steps expand the reciprocal, so numerator and denominator swap roles.
    function automatic t_ratio best_convergent(input t_word value, input t_word lim_num,
                                               input t_word lim_den);
        t_word den1, den2, num1, num2, dividend, divisor, term, rem, den_new, num_new;
        bit live;
        t_ratio r;
        den2 = '0;
        den1 = t_word'(1);
        num2 = t_word'(1);
        num1 = '0;
        dividend = ONE;
        divisor = value;
        live = (divisor != '0);
        while (live) begin
            term = dividend / divisor;
            rem = dividend % divisor;
            if (!conv_extend(term, den1, den2, den_new) ||
                !conv_extend(term, num1, num2, num_new) ||
                num_new > lim_num || den_new > lim_den) begin
                live = 1'b0;
            end else begin
                den2 = den1;
                den1 = den_new;
                num2 = num1;
                num1 = num_new;
                dividend = divisor;
                divisor = rem;
                live = (rem != '0);
            end
        end
        r.num = num1;
        r.den = den1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("ERROR at %0t: %s got 0x%016h, expected 0x%016h", $time, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_ratio want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_ratios.size() == 0) begin
                report_mismatch("unexpected result, numerator", o_numerator, '0);
            end else begin
                want = pending_ratios.pop_front();
                n_checked++;
                if (want.den == '0) n_no_fit++;
                if (o_numerator !== want.num) report_mismatch("numerator", o_numerator, want.num);
                if (o_denominator !== want.den) begin
                    report_mismatch("denominator", o_denominator, want.den);
                end
            end
        end
    end

    // Called just after a rising edge; returns just after the edge that took the transfer.
    task automatic transfer_item(input t_word value, input t_word lim_num, input t_word lim_den);
        start <= 1'b1;
        i_value_fixed <= value;
        i_max_num <= lim_num;
        i_max_den <= lim_den;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_ratios.insert(pending_ratios.size(), best_convergent(value, lim_num, lim_den));
        n_transfers++;
    endtask

    task automatic idle_sender(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        if (pending_ratios.size() != 0) begin
            start <= 1'b0;
            while (pending_ratios.size() != 0) @(posedge i_clk);
        end
    endtask

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // Limits are mostly small so that the expansion stays short.
    function automatic t_word rand_limit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return rand_word();
        if (pick < 9) return ALL_ONES;
        if (pick < 12) return t_word'($urandom_range(0, 1));
        return t_word'($urandom_range(0, (1 << $urandom_range(1, 12)) - 1));
    endfunction

    function automatic t_word rand_value();
        int pick;
        t_word p, q;
        pick = $urandom_range(0, 99);
        if (pick < 2) return '0;
        if (pick < 30) return t_word'($urandom) >> $urandom_range(0, 31);
        if (pick < 50) return rand_word();
        if (pick < 75) begin
            p = t_word'($urandom_range(0, 1000));
            q = t_word'($urandom_range(1, 1000));
            return (p << FRAC_BITS) / q;
        end
        if (pick < 87) begin
            p = t_word'(1) << $urandom_range(0, 63);
            return ($urandom_range(0, 1) != 0) ? p - 1 : p;
        end
        // Values close to a whole number from either side.
        p = t_word'($urandom_range(0, 20)) << FRAC_BITS;
        q = t_word'($urandom_range(1, 1 << 12));
        return ($urandom_range(0, 1) != 0) ? p + q : p - q;
    endfunction

    task automatic test_edge_values();
        transfer_item('0, ALL_ONES, ALL_ONES);
        transfer_item('0, '0, t_word'(1));
        transfer_item(ONE, ALL_ONES, ALL_ONES);
        transfer_item(ALL_ONES, ALL_ONES, ALL_ONES);
        transfer_item(ALL_ONES, '0, ALL_ONES);
        transfer_item(t_word'(1), ALL_ONES, ALL_ONES);
        transfer_item(64'h0000_0000_8000_0000, ALL_ONES, ALL_ONES);
        transfer_item(64'h0000_0000_FFFF_FFFF, ALL_ONES, ALL_ONES);
        transfer_item(64'h8000_0000_0000_0000, ALL_ONES, ALL_ONES);
        transfer_item(64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES, ALL_ONES);
        transfer_item(64'h5555_5555_5555_5555, t_word'(40), t_word'(9));
        // Golden ratio fraction: the leading terms are one, so the expansion runs long.
        transfer_item(64'h0000_0000_9E37_79B9, ALL_ONES, ALL_ONES);
        transfer_item(64'h0000_0007_C000_0000, ALL_ONES, t_word'(1));
    endtask

    task automatic test_limit_boundaries();
        // Pi: 355/113 fits exactly at these limits and not one below.
        transfer_item(64'h0000_0003_243F_6A88, t_word'(355), t_word'(113));
        transfer_item(64'h0000_0003_243F_6A88, t_word'(354), t_word'(113));
        transfer_item(64'h0000_0003_243F_6A88, t_word'(355), t_word'(112));
        transfer_item(64'h0000_0001_6A09_E667, t_word'(1000), t_word'(1000));
        // Zero denominator limit below one and above one.
        transfer_item(64'h0000_0000_4000_0000, ALL_ONES, '0);
        transfer_item(64'h0000_0002_4000_0000, ALL_ONES, '0);
        // Nothing fits above one, and nothing fits below one.
        transfer_item(t_word'(10) << FRAC_BITS, t_word'(5), ALL_ONES);
        transfer_item(64'h0000_0000_0000_1000, ALL_ONES, t_word'(5));
        transfer_item(64'h0000_0000_0000_1000, '0, ALL_ONES);
    endtask

    task automatic test_drained_restart(input int count);
        for (int i = 0; i < count; i++) begin
            wait_drained();
            transfer_item(rand_value(), rand_limit(), rand_limit());
        end
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 63) wait_drained();
            idle_sender(idle_pct);
            transfer_item(rand_value(), rand_limit(), rand_limit());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_values();
        test_limit_boundaries();
        test_drained_restart(8);
        test_random_traffic(345, 27);
        test_random_traffic(345, 84);
        test_random_traffic(345, 0);
        start <= 1'b0;
        while (pending_ratios.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Ran %0d transfers: edge values, limit boundaries, drained restarts and",
                 n_transfers);
        $display("three sender idle profiles; %0d results checked, %0d of them no-fit 1/0.",
                 n_checked, n_no_fit);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #250_000_000;
        $display("Timeout with %0d results still outstanding", pending_ratios.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ra_pkg.sv
sv/ra_div.sv
sv/ra_mac.sv
sv/rational_approximation.sv
bench/tb_top.sv
